FILE: src/cost_pkg.sv
package cost_pkg;

  // Item opcodes
  typedef enum logic [1:0] {
    ACT_SYNC  = 2'd0,
    ACT_SKIP  = 2'd1,
    ACT_RESET = 2'd2,
    ACT_QUERY = 2'd3
  } action_t;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROUND_TRIP_LIMIT     = 2'd0,
    CFG_STALE_THRESHOLD      = 2'd1,
    CFG_UNSYNCED_UNCERTAINTY = 2'd2
  } cfg_index_t;

  // Register reset values
  localparam logic [15:0] LIMIT_RESET    = 16'd5000;
  localparam logic [19:0] STALE_RESET    = 20'd20000;
  localparam logic [19:0] UNSYNCED_RESET = 20'd1000;

  localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_UNC,
    ST_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic ready;
    logic capture;
    logic apply;
    logic scan_step;
    logic unc_calc;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic    item_valid;
    action_t action;
    logic    scan_done;
    logic    out_free;
  } sts_t;

endpackage

FILE: src/cost_if.sv
interface cost_item_if;
  import cost_pkg::*;

  logic               valid;
  logic               ready;
  action_t            action;
  logic [31:0]        remote_ticks;
  logic [31:0]        sent_time;
  logic [31:0]        answer_time;
  logic signed [31:0] skip_ms;
  logic [31:0]        event_time;
  logic [31:0]        now_time;

  modport source (
    output valid, action, remote_ticks, sent_time, answer_time, skip_ms, event_time,
           now_time,
    input  ready
  );
  modport sink (
    input  valid, action, remote_ticks, sent_time, answer_time, skip_ms, event_time,
           now_time,
    output ready
  );
endinterface

interface cost_result_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic               known;
  logic signed [31:0] clock_offset;
  logic [14:0]        offset_spread;
  logic [30:0]        skew_since;
  logic [30:0]        uncertainty;

  modport source (
    output valid, accepted, known, clock_offset, offset_spread, skew_since, uncertainty,
    input  ready
  );
  modport sink (
    input  valid, accepted, known, clock_offset, offset_spread, skew_since, uncertainty,
    output ready
  );
endinterface

FILE: src/cost_ctrl.sv
module cost_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  cost_pkg::sts_t sts,
  output cost_pkg::cmd_t cmd
);
  import cost_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cmd.ready = 1'b1;
        if (sts.item_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.apply  = 1'b1;
        state_next = (sts.action == ACT_QUERY) ? ST_SCAN : ST_OUT;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_UNC;
        end
      end
      ST_UNC: begin
        cmd.unc_calc = 1'b1;
        state_next   = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/cost_dp.sv
module cost_dp #(
  parameter int HISTORY_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [cost_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cost_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  cost_pkg::cmd_t                   cmd,
  output cost_pkg::sts_t                   sts,
  cost_item_if.sink                        item,
  cost_result_if.source                    result
);
  import cost_pkg::*;

  localparam int HEAD_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W  = HEAD_W + 1;
  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(HISTORY_DEPTH);
  localparam logic [SUM_W-1:0]  DEPTH_SUM = SUM_W'(HISTORY_DEPTH);
  localparam logic [HEAD_W-1:0] LAST_PTR  = HEAD_W'(HISTORY_DEPTH - 1);

  function automatic logic [HEAD_W-1:0] ptr_inc(input logic [HEAD_W-1:0] p);
    ptr_inc = (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  // Configuration registers
  logic [15:0] round_trip_limit;
  logic [19:0] stale_threshold;
  logic [19:0] unsynced_uncertainty;

  always_ff @(posedge clk) begin
    if (rst) begin
      round_trip_limit     <= LIMIT_RESET;
      stale_threshold      <= STALE_RESET;
      unsynced_uncertainty <= UNSYNCED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROUND_TRIP_LIMIT:     round_trip_limit     <= cfg_data[15:0];
        CFG_STALE_THRESHOLD:      stale_threshold      <= cfg_data;
        CFG_UNSYNCED_UNCERTAINTY: unsynced_uncertainty <= cfg_data;
        default:                  ;
      endcase
    end
  end

  // Captured transaction
  action_t            act_q;
  logic [31:0]        ticks_q;
  logic [31:0]        sent_q;
  logic [31:0]        answer_q;
  logic signed [31:0] skip_q;
  logic [31:0]        evt_q;
  logic [31:0]        now_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q    <= item.action;
      ticks_q  <= item.remote_ticks;
      sent_q   <= item.sent_time;
      answer_q <= item.answer_time;
      skip_q   <= item.skip_ms;
      evt_q    <= item.event_time;
      now_q    <= item.now_time;
    end
  end

  assign item.ready = cmd.ready;

  // Tracker state
  logic [HEAD_W-1:0] hist_head;
  logic [CNT_W-1:0]  hist_count;
  logic [30:0]       skew_total;
  logic [31:0]       offset_value;
  logic [14:0]       spread_value;
  logic [31:0]       last_sync_time;
  logic              synced_flag;
  logic              accepted_q;
  logic [30:0]       excess_q;

  // Sync arithmetic
  logic [31:0] rtt;
  logic        rtt_ok;
  logic [14:0] half_rtt;
  logic [31:0] offset_new;

  assign rtt        = answer_q - sent_q;
  assign rtt_ok     = (rtt[31:16] == 16'd0) && (rtt[15:0] <= round_trip_limit);
  assign half_rtt   = rtt[15:1];
  assign offset_new = sent_q + {17'd0, half_rtt} - ticks_q;

  // Skip arithmetic
  logic        skip_ok;
  logic [31:0] skew_sum;
  logic [30:0] total_new;
  logic [SUM_W-1:0]  wrap_sum;
  logic [HEAD_W-1:0] append_slot;
  logic [HEAD_W-1:0] write_slot;
  logic              hist_full;
  logic              hist_we;

  assign skip_ok     = (skip_q != 32'sd0) && !skip_q[31];
  assign skew_sum    = {1'b0, skew_total} + {1'b0, skip_q[30:0]};
  assign total_new   = skew_sum[31] ? MAX31 : skew_sum[30:0];
  assign hist_full   = (hist_count == DEPTH_CNT);
  assign wrap_sum    = SUM_W'(hist_head) + SUM_W'(hist_count);
  assign append_slot = (wrap_sum >= DEPTH_SUM) ? HEAD_W'(wrap_sum - DEPTH_SUM)
                                               : HEAD_W'(wrap_sum);
  assign write_slot  = hist_full ? hist_head : append_slot;
  assign hist_we     = cmd.apply && (act_q == ACT_SKIP) && skip_ok;

  // Quiet time beyond the stale threshold
  logic [31:0] quiet;
  logic [32:0] excess_raw;
  logic        excess_pos;

  assign quiet      = now_q - last_sync_time;
  assign excess_raw = {quiet[31], quiet} - {13'd0, stale_threshold};
  assign excess_pos = !excess_raw[32] && (excess_raw != 33'd0);

  // Apply the transaction to the tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_head      <= '0;
      hist_count     <= '0;
      skew_total     <= '0;
      offset_value   <= '0;
      spread_value   <= '0;
      last_sync_time <= '0;
      synced_flag    <= 1'b0;
      accepted_q     <= 1'b0;
      excess_q       <= '0;
    end else if (cmd.apply) begin
      accepted_q <= 1'b0;
      case (act_q)
        ACT_SYNC: begin
          if (rtt_ok) begin
            offset_value   <= offset_new;
            spread_value   <= half_rtt;
            last_sync_time <= answer_q;
            synced_flag    <= 1'b1;
            accepted_q     <= 1'b1;
          end
        end
        ACT_SKIP: begin
          if (skip_ok) begin
            skew_total <= total_new;
            accepted_q <= 1'b1;
            if (hist_full) begin
              hist_head <= ptr_inc(hist_head);
            end else begin
              hist_count <= hist_count + 1'b1;
            end
          end
        end
        ACT_RESET: begin
          hist_head      <= '0;
          hist_count     <= '0;
          skew_total     <= '0;
          offset_value   <= '0;
          spread_value   <= '0;
          last_sync_time <= '0;
          synced_flag    <= 1'b0;
        end
        default: begin
          excess_q <= excess_pos ? excess_raw[30:0] : '0;
        end
      endcase
    end
  end

  // History memory: event time high, running total low
  logic [62:0]       hist_mem [HISTORY_DEPTH];
  logic [62:0]       rd_word;
  logic [HEAD_W-1:0] rd_ptr;
  logic              hist_re;

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[write_slot] <= {evt_q, total_new};
    end
    if (hist_re) begin
      rd_word <= hist_mem[rd_ptr];
    end
  end

  // Scan oldest to newest, stop at the first entry after the reference time
  logic [CNT_W-1:0] scan_idx;
  logic             rd_pend;
  logic             stopped;
  logic [30:0]      base_total;
  logic [31:0]      rd_diff;
  logic             rd_after;

  assign hist_re  = cmd.scan_step && (scan_idx != hist_count) && !stopped;
  assign rd_diff  = rd_word[62:31] - evt_q;
  assign rd_after = !rd_diff[31] && (rd_diff != 32'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      rd_pend    <= 1'b0;
      stopped    <= 1'b0;
      base_total <= '0;
      rd_ptr     <= '0;
    end else if (cmd.apply) begin
      scan_idx   <= '0;
      rd_pend    <= 1'b0;
      stopped    <= 1'b0;
      base_total <= '0;
      rd_ptr     <= hist_head;
    end else if (cmd.scan_step) begin
      rd_pend <= hist_re;
      if (hist_re) begin
        scan_idx <= scan_idx + 1'b1;
        rd_ptr   <= ptr_inc(rd_ptr);
      end
      if (rd_pend && !stopped) begin
        if (rd_after) begin
          stopped <= 1'b1;
        end else begin
          base_total <= rd_word[30:0];
        end
      end
    end
  end

  // Query results
  logic [16:0] spread3;
  logic [31:0] unc_sum;
  logic [30:0] since_q;
  logic [30:0] unc_q;

  assign spread3 = {2'b00, spread_value} + {1'b0, spread_value, 1'b0};
  assign unc_sum = {1'b0, excess_q} + {15'd0, spread3};

  always_ff @(posedge clk) begin
    if (cmd.unc_calc) begin
      since_q <= (skew_total > base_total) ? (skew_total - base_total) : '0;
      if (!synced_flag) begin
        unc_q <= {11'd0, unsynced_uncertainty};
      end else begin
        unc_q <= unc_sum[31] ? MAX31 : unc_sum[30:0];
      end
    end
  end

  // Output register
  logic res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_out) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.accepted      <= accepted_q;
      result.known         <= synced_flag;
      result.clock_offset  <= offset_value;
      result.offset_spread <= spread_value;
      result.skew_since    <= (act_q == ACT_QUERY) ? since_q : '0;
      result.uncertainty   <= (act_q == ACT_QUERY) ? unc_q : '0;
    end
  end

  assign result.valid = res_valid;

  // Status
  assign sts.item_valid = item.valid;
  assign sts.action     = act_q;
  assign sts.scan_done  = stopped || ((scan_idx == hist_count) && !rd_pend);
  assign sts.out_free   = !res_valid || result.ready;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    hist_count <= DEPTH_CNT)
    else $error("history count beyond depth");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!res_valid || result.ready))
    else $error("result overwritten before taken");

  a_reset_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.apply && act_q == ACT_RESET) |=> (hist_count == '0 && !synced_flag
      && skew_total == '0))
    else $error("reset action left state behind");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> (scan_idx <= hist_count))
    else $error("scan ran past history");

endmodule

FILE: src/clock_offset_skew_tracker.sv
// Channel   Dir   Role    Payload
// item      in    sink    action, remote_ticks, sent_time, answer_time, skip_ms,
//                         event_time, now_time
// result    out   source  accepted, known, clock_offset, offset_spread, skew_since,
//                         uncertainty
// cfg       in    write   cfg_we, cfg_index, cfg_data (20 bit)
//
// Sync, skip and reset pass through the idle, exec and out states; a query also passes the
// scan state, which reads the history memory one entry per cycle through one port, and the
// uncertainty state before out.
// One transaction is worked on at a time; the next is taken while a result waits.
// rst is synchronous and clears the controller, tracker and scan state, the result valid and
// the configuration registers. A stalled result holds in the output register until taken.
module clock_offset_skew_tracker #(
  parameter int HISTORY_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cost_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cost_pkg::CFG_DATA_W-1:0] cfg_data,
  cost_item_if.sink                       item,
  cost_result_if.source                   result
);
  import cost_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cost_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  cost_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .item      (item),
    .result    (result)
  );

endmodule

FILE: tb/tb_clock_offset_skew_tracker.sv
`timescale 1ns / 1ps

module tb_clock_offset_skew_tracker;
  import cost_pkg::*;

  localparam int     HIST_DEPTH    = 256;
  localparam int     DRAIN_CYCLES  = HIST_DEPTH + 40;
  localparam int     CYCLE_LIMIT   = 3_000_000;
  localparam int     PHASES        = 5;
  localparam int     PHASE_ITEMS   = 350;
  localparam int     HOLD_AT       = 500;
  localparam int     HOLD_CYCLES   = 3000;
  localparam int     IDLE_PCT      = 27;
  localparam int     REPORT_MAX    = 10;
  localparam longint SAT31         = longint'(MAX31);

  typedef struct {
    action_t            action;
    logic [31:0]        remote_ticks;
    logic [31:0]        sent_time;
    logic [31:0]        answer_time;
    logic signed [31:0] skip_ms;
    logic [31:0]        event_time;
    logic [31:0]        now_time;
  } req_t;

  typedef struct {
    logic               accepted;
    logic               known;
    logic signed [31:0] clock_offset;
    logic [14:0]        offset_spread;
    logic [30:0]        skew_since;
    logic [30:0]        uncertainty;
  } reply_t;

  typedef struct {
    req_t   req;
    bit     has_exp;
    reply_t exp;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cost_item_if   item_ch ();
  cost_result_if result_ch ();

  clock_offset_skew_tracker #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  // Tracker copy: registers
  logic [15:0] cfg_rt_limit;
  logic [19:0] cfg_stale;
  logic [19:0] cfg_unsynced;

  // Tracker copy: state
  logic [31:0] hist_time  [HIST_DEPTH];
  logic [30:0] hist_total [HIST_DEPTH];
  int          hist_head;
  int          hist_count;
  logic [30:0] skew_sum;
  logic [31:0] offset_est;
  logic [14:0] spread_est;
  logic [31:0] last_sync;
  logic        synced;

  reply_t   pending_replies [$];
  dir_row_t dir_rows [$];
  reply_t   observed_reply;
  reply_t   wanted_reply;

  int          mismatch_count;
  int          items_sent;
  int          cycle_count;
  bit          idling_on;
  bit          hold_used;
  int          hold_left;
  logic [31:0] local_ms;
  logic [31:0] last_answer;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Wrap-aware signed difference a - b
  function automatic longint wrap_diff(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return longint'($signed(d));
  endfunction

  function automatic void clear_tracker();
    hist_head  = 0;
    hist_count = 0;
    skew_sum   = '0;
    offset_est = '0;
    spread_est = '0;
    last_sync  = '0;
    synced     = 1'b0;
  endfunction

  // Advance the tracker copy by one transaction and return its reply
  function automatic reply_t track_item(req_t r);
    reply_t      o;
    longint      rtt;
    longint      sum;
    longint      u;
    longint      quiet;
    logic [31:0] half;
    logic [30:0] base;
    int          slot;
    o = '{default: 0};
    case (r.action)
      ACT_SYNC: begin
        rtt = wrap_diff(r.answer_time, r.sent_time);
        if (rtt >= 0 && rtt <= longint'(cfg_rt_limit)) begin
          half       = rtt[31:0] >> 1;
          offset_est = r.sent_time + half - r.remote_ticks;
          spread_est = half[14:0];
          last_sync  = r.answer_time;
          synced     = 1'b1;
          o.accepted = 1'b1;
        end
      end
      ACT_SKIP: begin
        if (r.skip_ms > 0) begin
          sum      = longint'(skew_sum) + longint'(r.skip_ms);
          skew_sum = (sum > SAT31) ? MAX31 : sum[30:0];
          if (hist_count < HIST_DEPTH) begin
            slot = (hist_head + hist_count) % HIST_DEPTH;
            hist_count++;
          end else begin
            slot      = hist_head;
            hist_head = (hist_head + 1) % HIST_DEPTH;
          end
          hist_time[slot]  = r.event_time;
          hist_total[slot] = skew_sum;
          o.accepted       = 1'b1;
        end
      end
      ACT_RESET: begin
        clear_tracker();
      end
      default: begin
        // Scan oldest to newest, stop at the first entry after the reference time
        base = '0;
        for (int i = 0; i < hist_count; i++) begin
          slot = (hist_head + i) % HIST_DEPTH;
          if (wrap_diff(hist_time[slot], r.event_time) > 0) break;
          base = hist_total[slot];
        end
        o.skew_since = (skew_sum > base) ? skew_sum - base : '0;
        if (!synced) begin
          o.uncertainty = 31'(cfg_unsynced);
        end else begin
          u     = 3 * longint'(spread_est);
          quiet = wrap_diff(r.now_time, last_sync);
          if (quiet > longint'(cfg_stale)) u += quiet - longint'(cfg_stale);
          o.uncertainty = (u > SAT31) ? MAX31 : u[30:0];
        end
      end
    endcase
    o.known         = synced;
    o.clock_offset  = offset_est;
    o.offset_spread = spread_est;
    return o;
  endfunction

  function automatic void add_row(req_t r, bit has_exp, reply_t e);
    dir_row_t row;
    row.req     = r;
    row.has_exp = has_exp;
    row.exp     = e;
    dir_rows.push_back(row);
  endfunction

  // Random transaction around a running local millisecond clock
  function automatic req_t next_random_item(bit allow_reset);
    req_t r;
    int   pick;
    int   sel;
    r.remote_ticks = $urandom;
    r.sent_time    = $urandom;
    r.answer_time  = $urandom;
    r.skip_ms      = $urandom;
    r.event_time   = $urandom;
    r.now_time     = $urandom;
    local_ms       = local_ms + $urandom_range(0, 3000);
    pick           = $urandom_range(0, 999);
    sel            = $urandom_range(0, 99);
    if (allow_reset && pick < 2) begin
      r.action = ACT_RESET;
    end else if (pick < 450) begin
      r.action = ACT_SKIP;
      if (sel < 5)       r.skip_ms = '0;
      else if (sel < 10) r.skip_ms = $urandom | 32'h8000_0000;
      else if (sel < 12) r.skip_ms = $urandom_range(0, 32'h7FFF_FFFF);
      else               r.skip_ms = $urandom_range(1, 5000);
      if ($urandom_range(0, 99) < 95) r.event_time = local_ms;
    end else if (pick < 750) begin
      r.action = ACT_QUERY;
      if (sel < 60)      r.event_time = local_ms - $urandom_range(0, 300000);
      else if (sel < 80) r.event_time = local_ms;
      sel = $urandom_range(0, 99);
      if (sel < 40)      r.now_time = local_ms;
      else if (sel < 80) r.now_time = last_answer + $urandom_range(0, 2 * cfg_stale + 2000);
    end else begin
      r.action    = ACT_SYNC;
      r.sent_time = local_ms - $urandom_range(0, 70000);
      if (sel < 10)      r.answer_time = r.sent_time - $urandom_range(1, 100000);
      else if (sel < 20) r.answer_time = r.sent_time + cfg_rt_limit + $urandom_range(1, 1000);
      else if (sel < 30) r.answer_time = r.sent_time + cfg_rt_limit;
      else if (sel < 65) r.answer_time = r.sent_time + $urandom_range(0, cfg_rt_limit);
      if (sel >= 5) last_answer = r.answer_time;
    end
    return r;
  endfunction

  // Offer one transaction, hold it until taken, then log what it should give
  task automatic send_item(req_t r, bit has_exp, reply_t e);
    reply_t predicted;
    @(negedge clk);
    while (idling_on && $urandom_range(0, 99) < IDLE_PCT) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.action       <= r.action;
    item_ch.remote_ticks <= r.remote_ticks;
    item_ch.sent_time    <= r.sent_time;
    item_ch.answer_time  <= r.answer_time;
    item_ch.skip_ms      <= r.skip_ms;
    item_ch.event_time   <= r.event_time;
    item_ch.now_time     <= r.now_time;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    items_sent++;
    predicted = track_item(r);
    pending_replies.push_back(has_exp ? e : predicted);
  endtask

  // Drop valid and let the block go quiet
  task automatic settle();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    wait (pending_replies.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_ROUND_TRIP_LIMIT:     cfg_rt_limit = val[15:0];
      CFG_STALE_THRESHOLD:      cfg_stale    = val;
      CFG_UNSYNCED_UNCERTAINTY: cfg_unsynced = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (!hold_used && items_sent >= HOLD_AT) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= !(idling_on && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Check each reply against the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      observed_reply.accepted      = result_ch.accepted;
      observed_reply.known         = result_ch.known;
      observed_reply.clock_offset  = result_ch.clock_offset;
      observed_reply.offset_spread = result_ch.offset_spread;
      observed_reply.skew_since    = result_ch.skew_since;
      observed_reply.uncertainty   = result_ch.uncertainty;
      if (pending_replies.size() == 0) begin
        if (mismatch_count < REPORT_MAX)
          $display("cycle %0d: reply with nothing expected", cycle_count);
        mismatch_count++;
      end else begin
        wanted_reply = pending_replies[0];
        pending_replies.delete(0);
        if (observed_reply.accepted      !== wanted_reply.accepted      ||
            observed_reply.known         !== wanted_reply.known         ||
            observed_reply.clock_offset  !== wanted_reply.clock_offset  ||
            observed_reply.offset_spread !== wanted_reply.offset_spread ||
            observed_reply.skew_since    !== wanted_reply.skew_since    ||
            observed_reply.uncertainty   !== wanted_reply.uncertainty) begin
          if (mismatch_count < REPORT_MAX) begin
            $display("cycle %0d: expected acc=%0b known=%0b off=%0d spr=%0d since=%0d unc=%0d",
                     cycle_count, wanted_reply.accepted, wanted_reply.known,
                     wanted_reply.clock_offset, wanted_reply.offset_spread,
                     wanted_reply.skew_since, wanted_reply.uncertainty);
            $display("            got      acc=%0b known=%0b off=%0d spr=%0d since=%0d unc=%0d",
                     observed_reply.accepted, observed_reply.known,
                     observed_reply.clock_offset, observed_reply.offset_spread,
                     observed_reply.skew_since, observed_reply.uncertainty);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [19:0] lim_val;
    logic [19:0] stale_val;
    logic [19:0] unsync_val;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    item_ch.valid        = 1'b0;
    item_ch.action       = ACT_SYNC;
    item_ch.remote_ticks = '0;
    item_ch.sent_time    = '0;
    item_ch.answer_time  = '0;
    item_ch.skip_ms      = '0;
    item_ch.event_time   = '0;
    item_ch.now_time     = '0;
    result_ch.ready      = 1'b0;
    mismatch_count       = 0;
    items_sent           = 0;
    cycle_count          = 0;
    idling_on            = 1'b1;
    hold_used            = 1'b0;
    hold_left            = 0;
    local_ms             = $urandom;
    last_answer          = local_ms;
    cfg_rt_limit         = LIMIT_RESET;
    cfg_stale            = STALE_RESET;
    cfg_unsynced         = UNSYNCED_RESET;
    clear_tracker();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset state, round-trip bounds, refused skips, saturation, wrap
    add_row('{ACT_QUERY, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0, 1000});
    add_row('{ACT_QUERY, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1,
            '{0, 0, 0, 0, 0, 1000});
    add_row('{ACT_SYNC, 0, 100, 99, 0, 0, 0}, 1, '{0, 0, 0, 0, 0, 0});
    add_row('{ACT_SYNC, 0, 0, 5001, 0, 0, 0}, 1, '{0, 0, 0, 0, 0, 0});
    add_row('{ACT_SYNC, 0, 1000, 6000, 0, 0, 0}, 1, '{1, 1, 3500, 2500, 0, 0});
    add_row('{ACT_SKIP, 0, 0, 0, 0, 10, 0}, 1, '{0, 1, 3500, 2500, 0, 0});
    add_row('{ACT_SKIP, 0, 0, 0, 32'sh8000_0000, 10, 0}, 1, '{0, 1, 3500, 2500, 0, 0});
    add_row('{ACT_SKIP, 0, 0, 0, -1, 10, 0}, 1, '{0, 1, 3500, 2500, 0, 0});
    add_row('{ACT_SKIP, 0, 0, 0, 32'sh7FFF_FFFF, 20000, 0}, 1,
            '{1, 1, 3500, 2500, 0, 0});
    add_row('{ACT_SKIP, 0, 0, 0, 1, 30000, 0}, 1, '{1, 1, 3500, 2500, 0, 0});
    add_row('{ACT_QUERY, 0, 0, 0, 0, 0, 6000}, 1,
            '{0, 1, 3500, 2500, 31'h7FFF_FFFF, 7500});
    add_row('{ACT_QUERY, 0, 0, 0, 0, 25000, 26001}, 1, '{0, 1, 3500, 2500, 0, 7501});
    add_row('{ACT_QUERY, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'h8000_176F}, 0, '{default: 0});
    add_row('{ACT_QUERY, 0, 0, 0, 0, 30000, 32'h8000_1770}, 0, '{default: 0});
    add_row('{ACT_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -1,
              32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1, '{0, 0, 0, 0, 0, 0});
    add_row('{ACT_QUERY, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0, 1000});
    add_row('{ACT_SYNC, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'h0000_0010, 0, 0, 0}, 1,
            '{1, 1, 1, 16, 0, 0});
    add_row('{ACT_SYNC, 32'h1234_5678, 32'h8000_0000, 32'h8000_0000, 0, 0, 0}, 0,
            '{default: 0});
    add_row('{ACT_SKIP, 0, 0, 0, 1000, 32'hFFFF_FFFF, 0}, 0, '{default: 0});
    add_row('{ACT_SKIP, 0, 0, 0, 500, 5, 0}, 0, '{default: 0});
    add_row('{ACT_QUERY, 0, 0, 0, 0, 0, 32'h8000_0000}, 0, '{default: 0});
    add_row('{ACT_QUERY, 0, 0, 0, 0, 32'hFFFF_FFFF, 0}, 0, '{default: 0});
    add_row('{ACT_SYNC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0}, 1,
            '{1, 1, 0, 0, 0, 0});
    add_row('{ACT_QUERY, 0, 0, 0, 0, 0, 0}, 0, '{default: 0});
    add_row('{ACT_SYNC, 0, 0, 32'h7FFF_FFFF, 0, 0, 0}, 0, '{default: 0});

    foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].has_exp, dir_rows[i].exp);

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin lim_val = 20'd0;     stale_val = 20'd0;       unsync_val = 20'd0;       end
        1: begin lim_val = 20'd65535; stale_val = 20'd1000000; unsync_val = 20'd1000000; end
        2: begin lim_val = 20'd5000;  stale_val = 20'd20000;   unsync_val = 20'd1000;    end
        3: begin lim_val = 20'd65535; stale_val = 20'd0;       unsync_val = 20'd1000000; end
        default: begin
          lim_val    = 20'($urandom_range(0, 65535));
          stale_val  = 20'($urandom_range(0, 1000000));
          unsync_val = 20'($urandom_range(0, 1000000));
        end
      endcase
      write_reg(CFG_ROUND_TRIP_LIMIT, lim_val);
      write_reg(CFG_STALE_THRESHOLD, stale_val);
      write_reg(CFG_UNSYNCED_UNCERTAINTY, unsync_val);
      // Phase 2 runs with no gaps on either side
      idling_on = (p != 2);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_item(next_random_item(p != 1 && p != 2), 0, '{default: 0});
    end
    idling_on = 1'b1;

    settle();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
